/* design/circular_fifo_queue_top_assert.svh */
// assertion macros used by the circular fifo queue datapath
`ifndef CIRCULAR_FIFO_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off while in reset
`define CFQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfq assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define CFQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfq assertion failed");

`else

`define CFQ_ASSERT_SAME(label, ante, cons)
`define CFQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/cfq_pkg.sv */
// shared types and constants of the circular fifo queue
`timescale 1ns / 1ps
`default_nettype none

package cfq_pkg;

    // request operation codes
    typedef enum logic [2:0] {
        OP_ENQUEUE    = 3'd0,
        OP_DEQUEUE    = 3'd1,
        OP_PEEK_FRONT = 3'd2,
        OP_PEEK_REAR  = 3'd3,
        OP_READ_COUNT = 3'd4
    } cfq_op_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } cfq_status_t;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } cfq_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch request, start slot read
        logic execute;   // apply update, load result register
    } cfq_cmd_t;

    // payload widths
    localparam int OP_W    = 3;
    localparam int ITEM_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CAP_W      = 5;
    localparam logic [0:0]       REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;

endpackage

`default_nettype wire

/* design/cfq_if.sv */
// request and result channel interfaces of the circular fifo queue
`timescale 1ns / 1ps
`default_nettype none

interface cfq_req_if;
    logic                         valid;
    logic                         ready;
    logic [cfq_pkg::OP_W-1:0]     op;
    logic [cfq_pkg::ITEM_W-1:0]   item_value;

    modport source (output valid, output op, output item_value, input ready);
    modport sink   (input valid, input op, input item_value, output ready);
endinterface

interface cfq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cfq_pkg::STAT_W-1:0]   status;
    logic [cfq_pkg::ITEM_W-1:0]   data_out;
    logic [cfq_pkg::COUNT_W-1:0]  count_out;

    modport source (output valid, output status, output data_out, output count_out,
                    input ready);
    modport sink   (input valid, input status, input data_out, input count_out,
                    output ready);
endinterface

`default_nettype wire

/* design/cfq_ctrl.sv */
// controller: request and result handshakes and sequencing of each item
`timescale 1ns / 1ps
`default_nettype none

module cfq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output cfq_pkg::cfq_cmd_t      cmd
);

    cfq_pkg::cfq_state_t state_reg;
    cfq_pkg::cfq_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                result_free;

    // result register is free when empty or being taken this cycle
    assign result_free = !out_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfq_pkg::ST_IDLE:
            begin
                if (req_valid && result_free)
                begin
                    state_next = cfq_pkg::ST_EXEC;
                end
            end
            cfq_pkg::ST_EXEC:
            begin
                state_next = cfq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cfq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            cfq_pkg::ST_IDLE:
            begin
                req_ready   = result_free;
                cmd.capture = req_valid && result_free;
            end
            cfq_pkg::ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* design/cfq_datapath.sv */
// datapath: slot memory, head and tail indexes, fill count and result register
`timescale 1ns / 1ps
`default_nettype none

`include "circular_fifo_queue_top_assert.svh"

module cfq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cfq_pkg::cfq_cmd_t              cmd,
    input  wire logic [cfq_pkg::CAP_W-1:0]      capacity_in_use,
    input  wire logic [cfq_pkg::OP_W-1:0]       op,
    input  wire logic [cfq_pkg::ITEM_W-1:0]     item_value,
    output logic [cfq_pkg::STAT_W-1:0]          status,
    output logic [cfq_pkg::ITEM_W-1:0]          data_out,
    output logic [cfq_pkg::COUNT_W-1:0]         count_out
);

    localparam int IW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > cfq_pkg::CAP_W) ? CNT_W : cfq_pkg::CAP_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // slot memory
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [cfq_pkg::OP_W-1:0]    op_reg;
    logic [DATA_WIDTH-1:0]       item_reg;
    logic [DATA_WIDTH-1:0]       rd_data_reg;
    logic [IW-1:0]               head_reg;
    logic [IW-1:0]               head_next;
    logic [IW-1:0]               tail_reg;
    logic [IW-1:0]               tail_next;
    logic [CW-1:0]               fill_count_reg;
    logic [CW-1:0]               fill_count_next;
    logic [cfq_pkg::STAT_W-1:0]  status_reg;
    logic [cfq_pkg::STAT_W-1:0]  status_next;
    logic [cfq_pkg::ITEM_W-1:0]  data_out_reg;
    logic [cfq_pkg::ITEM_W-1:0]  data_out_next;
    logic [cfq_pkg::COUNT_W-1:0] count_out_reg;
    logic [CW-1:0]               cap_raw;
    logic [CW-1:0]               cap_eff;
    logic [IW-1:0]               rear_index;
    logic [IW-1:0]               rd_addr;
    logic [CW-1:0]               fill_dec;
    logic                        is_full;
    logic                        is_empty;
    logic                        mem_we;
    logic [63:0]                 item_wide;
    logic [63:0]                 rd_wide;

    // index step with wrap at capacity or depth
    function automatic logic [IW-1:0] next_index(input logic [IW-1:0] idx,
                                                 input logic [CW-1:0] cap);
        logic [CW-1:0] n;
        n = CW'(idx) + CW'(1);
        if (n >= cap || n >= DEPTH_C)
        begin
            return '0;
        end
        return n[IW-1:0];
    endfunction

    // effective capacity: zero acts as one, clamp at depth
    assign cap_raw = CW'(capacity_in_use);
    always_comb
    begin
        if (cap_raw == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_raw > DEPTH_C)
        begin
            cap_eff = DEPTH_C;
        end
        else
        begin
            cap_eff = cap_raw;
        end
    end

    // newest slot, wraps back from slot zero to capacity - 1
    always_comb
    begin
        if (tail_reg == '0)
        begin
            rear_index = IW'(cap_eff - CW'(1));
        end
        else
        begin
            rear_index = tail_reg - IW'(1);
        end
    end

    // slot read address for the incoming item
    assign rd_addr = (op == cfq_pkg::OP_PEEK_REAR) ? rear_index : head_reg;

    // request capture and registered slot read
    assign item_wide = 64'(item_value);
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op;
            item_reg    <= item_wide[DATA_WIDTH-1:0];
            rd_data_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[tail_reg] <= item_reg;
        end
    end

    assign is_full  = fill_count_reg >= cap_eff;
    assign is_empty = fill_count_reg == '0;
    assign fill_dec = fill_count_reg - CW'(1);
    assign rd_wide  = 64'(rd_data_reg);

    // operation update
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_count_next = fill_count_reg;
        status_next     = cfq_pkg::STATUS_OK;
        data_out_next   = '0;
        mem_we          = 1'b0;
        unique case (op_reg) inside
            cfq_pkg::OP_ENQUEUE:
            begin
                if (is_full)
                begin
                    status_next = cfq_pkg::STATUS_FULL;
                end
                else
                begin
                    mem_we          = cmd.execute;
                    tail_next       = next_index(tail_reg, cap_eff);
                    fill_count_next = fill_count_reg + CW'(1);
                end
            end
            cfq_pkg::OP_DEQUEUE:
            begin
                if (is_empty)
                begin
                    status_next = cfq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    data_out_next   = rd_wide[cfq_pkg::ITEM_W-1:0];
                    fill_count_next = fill_dec;
                    if (fill_dec == '0)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        head_next = next_index(head_reg, cap_eff);
                    end
                end
            end
            cfq_pkg::OP_PEEK_FRONT, cfq_pkg::OP_PEEK_REAR:
            begin
                if (is_empty)
                begin
                    status_next = cfq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    data_out_next = rd_wide[cfq_pkg::ITEM_W-1:0];
                end
            end
            default:
            begin
                // read count and unused codes
                if (is_empty)
                begin
                    status_next = cfq_pkg::STATUS_EMPTY;
                end
            end
        endcase
    end

    // queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_count_reg <= fill_count_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg    <= status_next;
            data_out_reg  <= data_out_next;
            count_out_reg <= fill_count_next[cfq_pkg::COUNT_W-1:0];
        end
    end

    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign count_out = count_out_reg;

    // checks
    `CFQ_ASSERT_SAME(a_fill_bound, 1'b1, fill_count_reg <= DEPTH_C)
    `CFQ_ASSERT_SAME(a_empty_idx, fill_count_reg == '0, head_reg == '0 && tail_reg == '0)
    `CFQ_ASSERT_NEXT(a_enq_grow, mem_we, fill_count_reg == $past(fill_count_reg) + CW'(1))
    `CFQ_ASSERT_SAME(a_cmd_excl, 1'b1, !(cmd.capture && cmd.execute))

endmodule

`default_nettype wire

/* design/circular_fifo_queue_top.sv */
// top level of the circular fifo queue: channels, config register, submodules
//
//  channel | dir | payload                        | handshake
//  --------+-----+--------------------------------+--------------------------
//  req     | in  | op, item_value                 | valid / ready
//  rsp     | out | status, data_out, count_out    | valid / ready
//  apb     | in  | capacity_in_use at address 0   | psel, penable, pready = 1
//
//  each item is first captured, which issues the slot read, and then applies
//  the update and loads the result register; the registered slot read sets
//  this order.
//  reset clears head, tail and count and sets capacity to 16; slots are not
//  cleared, so the block takes items as soon as reset ends.
//  a result waits in its register until taken; the next item is accepted in
//  the same cycle the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none

module circular_fifo_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    cfq_req_if.sink                                req,
    cfq_rsp_if.source                              rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cfq_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [cfq_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [cfq_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    logic [cfq_pkg::CAP_W-1:0] capacity_reg;
    logic                      cfg_write;
    logic                      cap_sel;
    cfq_pkg::cfq_cmd_t         cmd;

    // config register decode
    assign pready    = 1'b1;
    assign cap_sel   = paddr[cfq_pkg::CFG_ADDR_W-1:2] == cfq_pkg::REG_CAPACITY;
    assign cfg_write = psel && penable && pwrite && pready && cap_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cfq_pkg::CAP_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= pwdata[cfq_pkg::CAP_W-1:0];
        end
    end

    // config read back
    assign prdata = cap_sel ? cfq_pkg::CFG_DATA_W'(capacity_reg) : '0;

    // controller
    cfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // datapath
    cfq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .capacity_in_use (capacity_reg),
        .op              (req.op),
        .item_value      (req.item_value),
        .status          (rsp.status),
        .data_out        (rsp.data_out),
        .count_out       (rsp.count_out)
    );

endmodule

`default_nettype wire
